// ===== src/easter_holy_day_dates_macros.svh =====
// Assertion macros shared by the holy-day date generator modules.
`ifndef EASTER_HOLY_DAY_DATES_MACROS_SVH
`define EASTER_HOLY_DAY_DATES_MACROS_SVH
// Property that must hold at every rising edge of clk outside reset.
`define EHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a rising edge of clk outside reset.
`define EHD_NEVER(label, expr, msg) \
    `EHD_ASSERT(label, !(expr), msg)
`endif

// ===== src/ehd_pkg.sv =====
// Shared types, constants and date tables for the holy-day date generator.
package ehd_pkg;

    localparam int YEAR_W    = 16;
    localparam int HOLIDAY_W = 3;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int DOY_W     = 8;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QCNT_W-1:0] qcnt_t;

    localparam qcnt_t QFULL = QCNT_W'(QDEPTH);

    localparam logic [HOLIDAY_W-1:0] HOLIDAY_FIRST = 3'd0;
    localparam logic [HOLIDAY_W-1:0] HOLIDAY_LAST  = 3'd5;

    typedef struct packed {
        logic [DOY_W-1:0] easter_doy;
        logic             leap;
    } ehd_entry_t;

    typedef struct packed {
        logic       valid;
        ehd_entry_t entry;
    } ehd_push_t;

    typedef struct packed {
        logic       empty;
        ehd_entry_t head;
    } ehd_qstat_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } ehd_back_state_t;

    function automatic logic signed [7:0] holiday_offset(input logic [HOLIDAY_W-1:0] idx);
        logic signed [7:0] off;
        case (idx)
            3'd0:    off = -8'sd49;
            3'd1:    off = -8'sd47;
            3'd2:    off = -8'sd2;
            3'd3:    off = 8'sd0;
            3'd4:    off = 8'sd39;
            3'd5:    off = 8'sd49;
            default: off = 8'sd0;
        endcase
        return off;
    endfunction

    // Number of days in the year before the first of the given month.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mon, input logic leap);
        logic [8:0] extra;
        logic [8:0] n;
        extra = 9'(leap);
        case (mon)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59 + extra;
            4'd4:    n = 9'd90 + extra;
            4'd5:    n = 9'd120 + extra;
            4'd6:    n = 9'd151 + extra;
            4'd7:    n = 9'd181 + extra;
            4'd8:    n = 9'd212 + extra;
            4'd9:    n = 9'd243 + extra;
            4'd10:   n = 9'd273 + extra;
            4'd11:   n = 9'd304 + extra;
            4'd12:   n = 9'd334 + extra;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/ehd_front.sv =====
// Front end: accepts years and computes the Easter day of the year in a six-stage pipeline.
module ehd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ehd_pkg::YEAR_W-1:0]   year,
    input  logic                         pop,
    output logic                         busy,
    output ehd_pkg::ehd_push_t           push
);

    ehd_pkg::qcnt_t cnt_reg, cnt_next;
    logic [5:0]     vld_reg, vld_next;
    logic           accept;

    logic [15:0] yr1_reg;
    logic [9:0]  q100e1_reg, q100e1_next;
    logic [11:0] q19e1_reg, q19e1_next;

    logic [4:0]  a2_reg, a2_next;
    logic [9:0]  b2_reg, b2_next;
    logic [6:0]  c2_reg, c2_next;
    logic        leap2_reg, leap2_next;
    logic [16:0] r100;
    logic        fix100;
    logic [15:0] r19;

    logic [4:0]  a3_reg;
    logic [9:0]  b3_reg;
    logic [6:0]  c3_reg;
    logic        leap3_reg;
    logic [4:0]  f3_reg, f3_next;
    logic [9:0]  fx, fr;
    logic [4:0]  fqe;

    logic [4:0]  a4_reg;
    logic [9:0]  b4_reg;
    logic [6:0]  c4_reg;
    logic        leap4_reg;
    logic [7:0]  g4_reg, g4_next;
    logic [9:0]  gx, gr;
    logic [7:0]  gqe;

    logic [4:0]  a5_reg;
    logic [1:0]  e5_reg;
    logic [6:0]  c5_reg;
    logic        leap5_reg;
    logic [4:0]  h5_reg, h5_next;
    logic [10:0] hx, hr;
    logic [5:0]  hqe;

    logic [4:0]  a6_reg;
    logic [4:0]  h6_reg;
    logic        leap6_reg;
    logic [2:0]  l6_reg, l6_next;
    logic [7:0]  lx, lr;
    logic [3:0]  lqe;

    logic [8:0]  mx;
    logic [7:0]  base;

    assign busy   = (cnt_reg == ehd_pkg::QFULL);
    assign accept = start && !busy;

    always_comb
    begin
        case ({accept, pop})
            2'b10:   cnt_next = cnt_reg + ehd_pkg::qcnt_t'(1);
            2'b01:   cnt_next = cnt_reg - ehd_pkg::qcnt_t'(1);
            default: cnt_next = cnt_reg;
        endcase
        vld_next = {vld_reg[4:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
        end
    end

    // Quotients by 100 and 19 use scaled reciprocals; each estimate is at most one low.
    always_comb
    begin
        q100e1_next = 10'((27'(year) * 27'd1310) >> 17);
        q19e1_next  = 12'((28'(year) * 28'd3449) >> 16);

        r100    = 17'(yr1_reg) - 17'(q100e1_reg) * 17'd100;
        fix100  = (r100 >= 17'd100);
        b2_next = q100e1_reg + 10'(fix100);
        c2_next = fix100 ? 7'(r100 - 17'd100) : 7'(r100);
        r19     = yr1_reg - 16'(q19e1_reg) * 16'd19;
        a2_next = (r19 >= 16'd19) ? 5'(r19 - 16'd19) : 5'(r19);
        leap2_next = (yr1_reg[1:0] == 2'd0) && ((c2_next != 7'd0) || (b2_next[1:0] == 2'd0));

        fx      = b2_reg + 10'd8;
        fqe     = 5'((15'(fx) * 15'd40) >> 10);
        fr      = fx - 10'(fqe) * 10'd25;
        f3_next = fqe + 5'(fr >= 10'd25);

        gx      = b3_reg - 10'(f3_reg) + 10'd1;
        gqe     = 8'((18'(gx) * 18'd341) >> 10);
        gr      = gx - 10'(gqe) * 10'd3;
        g4_next = gqe + 8'(gr >= 10'd3);

        hx      = 11'(a4_reg) * 11'd19 + 11'(b4_reg) - 11'(b4_reg[9:2]) - 11'(g4_reg) + 11'd15;
        hqe     = 6'((16'(hx) * 16'd34) >> 10);
        hr      = hx - 11'(hqe) * 11'd30;
        h5_next = (hr >= 11'd30) ? 5'(hr - 11'd30) : 5'(hr);

        lx      = 8'd32 + 8'({e5_reg, 1'b0}) + 8'({c5_reg[6:2], 1'b0})
                  - 8'(h5_reg) - 8'(c5_reg[1:0]);
        lqe     = 4'((12'(lx) * 12'd36) >> 8);
        lr      = lx - 8'(lqe) * 8'd7;
        l6_next = (lr >= 8'd7) ? 3'(lr - 8'd7) : 3'(lr);

        mx   = 9'(a6_reg) + 9'(h6_reg) * 9'd11 + 9'(l6_reg) * 9'd22;
        base = 8'(h6_reg) + 8'(l6_reg) + 8'd114 - ((mx >= 9'd451) ? 8'd7 : 8'd0);

        // March and April both reduce to the same day-of-year formula.
        push.valid            = vld_reg[5];
        push.entry.easter_doy = base - 8'd33 + 8'(leap6_reg);
        push.entry.leap       = leap6_reg;
    end

    always_ff @(posedge clk)
    begin
        yr1_reg    <= year;
        q100e1_reg <= q100e1_next;
        q19e1_reg  <= q19e1_next;

        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        c2_reg    <= c2_next;
        leap2_reg <= leap2_next;

        a3_reg    <= a2_reg;
        b3_reg    <= b2_reg;
        c3_reg    <= c2_reg;
        leap3_reg <= leap2_reg;
        f3_reg    <= f3_next;

        a4_reg    <= a3_reg;
        b4_reg    <= b3_reg;
        c4_reg    <= c3_reg;
        leap4_reg <= leap3_reg;
        g4_reg    <= g4_next;

        a5_reg    <= a4_reg;
        e5_reg    <= b4_reg[1:0];
        c5_reg    <= c4_reg;
        leap5_reg <= leap4_reg;
        h5_reg    <= h5_next;

        a6_reg    <= a5_reg;
        h6_reg    <= h5_reg;
        leap6_reg <= leap5_reg;
        l6_reg    <= l6_next;
    end

endmodule

// ===== src/ehd_queue.sv =====
// Four-entry queue that holds computed Easter days between the front and back ends.
`include "easter_holy_day_dates_macros.svh"

module ehd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ehd_pkg::ehd_push_t   push,
    input  logic                 pop,
    output ehd_pkg::ehd_qstat_t  stat
);

    ehd_pkg::ehd_entry_t mem_reg [ehd_pkg::QDEPTH];
    ehd_pkg::qptr_t      wr_ptr_reg, wr_ptr_next;
    ehd_pkg::qptr_t      rd_ptr_reg, rd_ptr_next;
    ehd_pkg::qcnt_t      cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + ehd_pkg::qptr_t'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + ehd_pkg::qptr_t'(1) : rd_ptr_reg;
        case ({push.valid, pop})
            2'b10:   cnt_next = cnt_reg + ehd_pkg::qcnt_t'(1);
            2'b01:   cnt_next = cnt_reg - ehd_pkg::qcnt_t'(1);
            default: cnt_next = cnt_reg;
        endcase
        stat.empty = (cnt_reg == '0);
        stat.head  = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `EHD_NEVER(aq_overflow, push.valid && (cnt_reg == ehd_pkg::QFULL), "queue written while full")
    `EHD_NEVER(aq_underflow, pop && (cnt_reg == '0), "queue read while empty")

endmodule

// ===== src/ehd_back.sv =====
// Back end: offsets the Easter day and converts six dates to month and day, one per cycle.
`include "easter_holy_day_dates_macros.svh"

module ehd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ehd_pkg::ehd_qstat_t             qstat,
    output logic                            pop,
    output logic                            valid,
    output logic [ehd_pkg::HOLIDAY_W-1:0]   holiday,
    output logic [ehd_pkg::MONTH_W-1:0]     month,
    output logic [ehd_pkg::DAY_W-1:0]       day,
    output logic                            last
);

    ehd_pkg::ehd_back_state_t           state_reg, state_next;
    logic [ehd_pkg::HOLIDAY_W-1:0]      k_reg, k_next;
    ehd_pkg::ehd_entry_t                entry_reg;
    logic                               run;
    logic                               at_last;

    logic signed [7:0]                  off;
    logic signed [9:0]                  doy_raw;
    logic [8:0]                         doy;
    logic [ehd_pkg::MONTH_W-1:0]        mon;
    logic [ehd_pkg::DAY_W-1:0]          dom;

    logic                               valid_reg;
    logic [ehd_pkg::HOLIDAY_W-1:0]      holiday_reg;
    logic [ehd_pkg::MONTH_W-1:0]        month_reg;
    logic [ehd_pkg::DAY_W-1:0]          day_reg;
    logic                               last_reg;

    assign at_last = (k_reg == ehd_pkg::HOLIDAY_LAST);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ehd_pkg::BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = ehd_pkg::BK_RUN;
                end
            end
            ehd_pkg::BK_RUN:
            begin
                if (at_last && qstat.empty)
                begin
                    state_next = ehd_pkg::BK_IDLE;
                end
            end
            default: state_next = ehd_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        run = 1'b0;
        unique case (state_reg)
            ehd_pkg::BK_IDLE:
            begin
                pop = !qstat.empty;
            end
            ehd_pkg::BK_RUN:
            begin
                run = 1'b1;
                pop = at_last && !qstat.empty;
            end
            default:
            begin
                pop = 1'b0;
                run = 1'b0;
            end
        endcase
        if (pop)
        begin
            k_next = ehd_pkg::HOLIDAY_FIRST;
        end
        else if (run)
        begin
            k_next = k_reg + 3'd1;
        end
        else
        begin
            k_next = k_reg;
        end
    end

    always_comb
    begin
        off     = ehd_pkg::holiday_offset(k_reg);
        doy_raw = $signed({2'b00, entry_reg.easter_doy}) + {{2{off[7]}}, off};
        doy     = (doy_raw < 10'sd1) ? 9'd1 : doy_raw[8:0];
        mon     = 4'd1;
        for (int j = 2; j <= 12; j++)
        begin
            if (doy > ehd_pkg::days_before(4'(j), entry_reg.leap))
            begin
                mon = 4'(j);
            end
        end
        dom = 5'(doy - ehd_pkg::days_before(mon, entry_reg.leap));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ehd_pkg::BK_IDLE;
            k_reg     <= ehd_pkg::HOLIDAY_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            valid_reg <= run;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg <= qstat.head;
        end
        holiday_reg <= k_reg;
        month_reg   <= mon;
        day_reg     <= dom;
        last_reg    <= at_last;
    end

    assign valid   = valid_reg;
    assign holiday = holiday_reg;
    assign month   = month_reg;
    assign day     = day_reg;
    assign last    = last_reg && valid_reg;

    `EHD_ASSERT(ab_order, valid_reg && !last |=> valid_reg && (holiday_reg == $past(holiday_reg) + 3'd1), "dates of one year are not consecutive")
    `EHD_ASSERT(ab_range, valid_reg |-> (month_reg >= 4'd2) && (month_reg <= 4'd6) && (day_reg != 5'd0), "date outside February to June")

endmodule

// ===== src/easter_holy_day_dates.sv =====
// Top level of the holy-day date generator: front end, queue and back end.
//
// A year is taken at a rising clock edge where start is high and busy is low.
// For each year the block gives six words on holiday, month, day and last,
// one per cycle, each marked by valid for exactly one cycle: carnival start,
// carnival end, good friday, easter, ascension and whitsuntide; last is high
// on the sixth. The receiver always takes a word in the cycle it is shown.
// A year passes the front end, the queue, the back end's entry register and
// its output registers before its first word is on the ports. The front
// end is a six-stage pipeline of constant divisions; the back end converts
// one date per cycle and so sets the sustained rate. busy rises when four
// years are in flight between acceptance and the back end taking them for
// conversion.
// Reset empties the pipeline and queue and drops valid; no clearing pass.
module easter_holy_day_dates (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ehd_pkg::YEAR_W-1:0]      year,
    output logic                            busy,
    output logic                            valid,
    output logic [ehd_pkg::HOLIDAY_W-1:0]   holiday,
    output logic [ehd_pkg::MONTH_W-1:0]     month,
    output logic [ehd_pkg::DAY_W-1:0]       day,
    output logic                            last
);

    ehd_pkg::ehd_push_t  push;
    ehd_pkg::ehd_qstat_t qstat;
    logic                pop;

    ehd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .year  (year),
        .pop   (pop),
        .busy  (busy),
        .push  (push)
    );

    ehd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .stat  (qstat)
    );

    ehd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .pop     (pop),
        .valid   (valid),
        .holiday (holiday),
        .month   (month),
        .day     (day),
        .last    (last)
    );

endmodule
